// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ITEM_BITS     = 32;
    localparam int PRIO_BITS     = 16;
    localparam int COUNT_BITS    = 5;
    localparam int CAPACITY_DEF  = 16;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [ITEM_BITS-1:0]        item_in;
        logic signed [PRIO_BITS-1:0] priority_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [ITEM_BITS-1:0]        out_item;
        logic [ITEM_BITS-1:0]        head_item;
        logic signed [PRIO_BITS-1:0] head_priority;
        logic [COUNT_BITS-1:0]       entry_count;
        logic                        is_empty;
        logic                        is_full;
    } out_word_t;

    typedef struct packed {
        logic [ITEM_BITS-1:0]        item;
        logic signed [PRIO_BITS-1:0] prio;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ins;
    } cell_ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  logic      left_keep,
    input  entry_t    left_data,
    input  entry_t    right_data,
    output logic      keep,
    output entry_t    data
);

    entry_t data_reg;
    entry_t data_next;

    // stays put when it orders at or before the new entry (ties keep FIFO order)
    assign keep = occupied && (data_reg.prio <= ctl.ins.prio);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.enq)
        begin
            if (!keep)
            begin
                data_next = left_keep ? ctl.ins : left_data;
            end
        end
        else if (ctl.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/stable_sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded min-first priority queue built as a row of sorted register cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (enqueue, dequeue or clear) is taken on a clock edge with
//   start high and busy low. busy is always low: one command per cycle.
//   Every command gives one result word on result, marked by done for one
//   cycle, in the cycle right after the command was taken.
//   Throughput is one command per cycle; each cell compares its priority to
//   the new one and either holds, loads the new entry or takes its neighbor's
//   entry, so an insert or pop updates every cell of the row on the same edge.
//   Equal priorities leave in arrival order. Enqueue when full and dequeue
//   when empty are refused and reported in status; the queue is unchanged.
//   The result carries the removed item, the head entry, count and flags.
//   Reset empties the queue at once; cell contents are not cleared and are
//   never shown while outside the occupied range.
//   The receiver cannot stall: the result must be taken in the done cycle.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  cmd,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [ITEM_BITS-1:0] removed_reg;
    logic [ITEM_BITS-1:0] removed_next;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    cell_ctl_t ctl;

    logic   [CAPACITY-1:0] occ;
    logic   [CAPACITY-1:0] keep;
    entry_t                cell_data [CAPACITY];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        ctl.enq      = 1'b0;
        ctl.deq      = 1'b0;
        ctl.ins.item = cmd.item_in;
        ctl.ins.prio = cmd.priority_in;
        count_next   = count_reg;
        status_next  = ST_DONE;
        removed_next = '0;
        if (accept)
        begin
            unique case (cmd.kind)
                KIND_ENQUEUE:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.enq    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_DEQUEUE:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.deq      = 1'b1;
                        removed_next = cell_data[0].item;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // unused code: no change
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t left_d;
            entry_t right_d;
            logic   left_k;

            assign occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_k = 1'b1;
                assign left_d = ctl.ins;
            end
            else
            begin : g_mid
                assign left_k = keep[i-1];
                assign left_d = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner
                assign right_d = cell_data[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (occ[i]),
                .left_keep  (left_k),
                .left_data  (left_d),
                .right_data (right_d),
                .keep       (keep[i]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // head and count are read live: the next command only lands at the end
    // of the done cycle
    always_comb
    begin
        result.status        = status_reg;
        result.out_item      = removed_reg;
        result.head_item     = is_empty ? '0 : cell_data[0].item;
        result.head_priority = is_empty ? '0 : cell_data[0].prio;
        result.entry_count   = COUNT_BITS'(count_reg);
        result.is_empty      = is_empty;
        result.is_full       = is_full;
    end

    assign done = done_reg;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stable sorted priority queue unit. A software
// copy of the queue predicts every result word; the checker compares each
// strobed result field by field with the oldest prediction. Directed words
// cover the corners, then random traffic with bursty starts exercises
// ordering, ties, full and empty refusals, clears and the unused kind.
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_word_t  cmd;
    logic      busy;
    logic      done;
    out_word_t result;

    stable_sorted_priority_queue_unit #(.CAPACITY(CAP)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // software copy of the queue
    logic [ITEM_BITS-1:0]        model_item [CAP];
    logic signed [PRIO_BITS-1:0] model_prio [CAP];
    int                          model_count;

    out_word_t pending_results[$];
    int        mismatches;
    int        results_seen;
    int        cycles;
    int        burst_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic out_word_t queue_apply(in_word_t w);
        out_word_t                   r;
        logic signed [PRIO_BITS-1:0] p;
        int                          pos;
        r = '0;
        p = w.priority_in;
        r.status = ST_DONE;
        case (w.kind)
            KIND_ENQUEUE:
                if (model_count >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    // after every entry of lower or equal priority: keeps ties FIFO
                    pos = 0;
                    while (pos < model_count && model_prio[pos] <= p)
                        pos++;
                    for (int i = model_count; i > pos; i--)
                    begin
                        model_item[i] = model_item[i-1];
                        model_prio[i] = model_prio[i-1];
                    end
                    model_item[pos] = w.item_in;
                    model_prio[pos] = p;
                    model_count++;
                end
            KIND_DEQUEUE:
                if (model_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_item = model_item[0];
                    for (int i = 1; i < model_count; i++)
                    begin
                        model_item[i-1] = model_item[i];
                        model_prio[i-1] = model_prio[i];
                    end
                    model_count--;
                end
            KIND_CLEAR:
                model_count = 0;
            default: ;
        endcase
        r.head_item     = (model_count != 0) ? model_item[0] : '0;
        r.head_priority = (model_count != 0) ? model_prio[0] : '0;
        r.entry_count   = COUNT_BITS'(model_count);
        r.is_empty      = (model_count == 0);
        r.is_full       = (model_count >= CAP);
        return r;
    endfunction

    function automatic in_word_t make_word(logic [1:0] k, logic [ITEM_BITS-1:0] it,
                                           logic [PRIO_BITS-1:0] pr);
        in_word_t w;
        w.kind        = k;
        w.item_in     = it;
        w.priority_in = pr;
        return w;
    endfunction

    // narrow priorities give plenty of ties; wide ones hit the sign boundary
    function automatic in_word_t random_word(int enq_pct, bit narrow);
        in_word_t w;
        int       r;
        r = $urandom_range(0, 99);
        w.item_in = $urandom;
        if (narrow)
            w.priority_in = PRIO_BITS'($signed($urandom_range(0, 3)) - 1);
        else if ($urandom_range(0, 7) == 0)
            w.priority_in = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        else
            w.priority_in = PRIO_BITS'($urandom);
        if (r < 2)
            w.kind = KIND_CLEAR;
        else if (r < 4)
            w.kind = KIND_UNUSED;
        else if (r < 4 + enq_pct * 96 / 100)
            w.kind = KIND_ENQUEUE;
        else
            w.kind = KIND_DEQUEUE;
        return w;
    endfunction

    // one command word, with bursty idle gaps ahead of it
    task automatic send_word(in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                cmd   <= in_word_t'({$urandom, $urandom});
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(queue_apply(w));
    endtask

    task automatic field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s, result %0d: expected %h, got %h",
                         name, results_seen, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing pending: %h", result);
            end
            else
            begin
                e = pending_results.pop_front();
                field_check("status", e.status, result.status);
                field_check("out_item", e.out_item, result.out_item);
                field_check("head_item", e.head_item, result.head_item);
                field_check("head_priority", e.head_priority, result.head_priority);
                field_check("entry_count", e.entry_count, result.entry_count);
                field_check("is_empty", e.is_empty, result.is_empty);
                field_check("is_full", e.is_full, result.is_full);
            end
            results_seen++;
        end
    end

    task automatic test_directed();
        send_word(make_word(KIND_DEQUEUE, 32'h0, 16'h0));
        send_word(make_word(KIND_CLEAR, 32'h0, 16'h0));
        send_word(make_word(KIND_UNUSED, 32'hffff_ffff, 16'h8000));
        send_word(make_word(KIND_ENQUEUE, 32'hffff_ffff, 16'h7fff));
        send_word(make_word(KIND_ENQUEUE, 32'h0, 16'h8000));
        send_word(make_word(KIND_ENQUEUE, 32'h1, 16'h0));
        send_word(make_word(KIND_ENQUEUE, 32'h2, 16'hffff));
        // equal priorities must come out in arrival order
        for (int i = 0; i < 3; i++)
            send_word(make_word(KIND_ENQUEUE, 32'h10 + i, 16'd5));
        send_word(make_word(KIND_DEQUEUE, 32'h0, 16'h0));
        for (int i = 0; i < 10; i++)
            send_word(make_word(KIND_ENQUEUE, 32'h20 + i, i[0] ? 16'd5 : 16'hffff));
        send_word(make_word(KIND_ENQUEUE, 32'hdead_beef, 16'h8000));
        send_word(make_word(KIND_UNUSED, 32'hffff_ffff, 16'hffff));
        send_word(make_word(KIND_DEQUEUE, 32'h0, 16'h0));
        send_word(make_word(KIND_CLEAR, 32'hffff_ffff, 16'h7fff));
    endtask

    task automatic test_random_mix(int n);
        int bias;
        bias = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
                bias = $urandom_range(20, 80);
            send_word(random_word(bias, $urandom_range(0, 3) == 0));
        end
    endtask

    task automatic test_tied_priorities(int n);
        for (int i = 0; i < n; i++)
            send_word(random_word(55, 1'b1));
    endtask

    // repeated runs up toward or past full and down toward or past empty
    task automatic test_fill_drain(int rounds);
        in_word_t w;
        int       len;
        for (int r = 0; r < rounds; r++)
        begin
            len = $urandom_range(CAP - 2, CAP + 6);
            for (int i = 0; i < len; i++)
            begin
                w = random_word(100, r[0]);
                w.kind = KIND_ENQUEUE;
                send_word(w);
            end
            len = $urandom_range(CAP - 2, CAP + 6);
            for (int i = 0; i < len; i++)
            begin
                w = random_word(0, 1'b0);
                w.kind = ($urandom_range(0, 39) == 0) ? KIND_CLEAR : KIND_DEQUEUE;
                send_word(w);
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        model_count = 0;
        mismatches  = 0;
        results_seen = 0;
        cycles      = 0;
        burst_left  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(1000);
        test_tied_priorities(400);
        test_fill_drain(10);

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
